>>> rtl/signed_int_to_decimal_ascii_unit_assert.svh
// Assertion macros shared by the decimal ASCII converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/itoa_pkg.sv
// Constants shared by the decimal ASCII converter.
`default_nettype none
package itoa_pkg;
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CHAR_BITS          = 6;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
endpackage
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii_unit.sv
// Flow: after a value is accepted, double dabble converts its magnitude (one magnitude bit
// per cycle), then leading zero digits are stripped one at a time (at most DIGITS-1), and
// each character is registered on its way out.
// Characters leave one per cycle while the receiver takes them: 1 to DIGITS+1 transfers,
// the sign first if negative. A new value is not accepted until the last character of the
// previous one is registered. Reset clears the state machine, sign flag and output valid.
`default_nettype none
`include "signed_int_to_decimal_ascii_unit_assert.svh"
module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,   // value
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [7:0]                               rsp_tdata,   // char_code
   output logic                                     rsp_tlast    // last_char
);
   import itoa_pkg::*;

   // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
   localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W  = 4 * DIGITS;
   localparam int CNT_W  = $clog2(VALUE_BITS);
   localparam int DIG_W  = $clog2(DIGITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIG_W-1:0]      dig_left_ff, dig_left_in;
   logic                  sign_ff, sign_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0] value;
   logic                  neg;
   logic                  accept;
   logic                  out_free;
   logic [3:0]            top_digit;

   assign value     = req_tdata[VALUE_BITS-1:0];
   assign neg       = value[VALUE_BITS-1];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // add 3 to every digit of five or more ahead of the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                         : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      dig_left_in  = dig_left_ff;
      sign_in      = sign_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // most negative value negates to itself, which is its magnitude unsigned
               mag_in   = neg ? (~value + 1'b1) : value;
               sign_in  = neg;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               dig_left_in = DIG_W'(DIGITS);
               state_in    = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // keep at least one digit so zero prints as '0'
            if (top_digit == 4'd0 && dig_left_ff != DIG_W'(1)) begin
               bcd_in      = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_left_in = dig_left_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (sign_ff) begin
                  out_char_in = CHAR_MINUS;
                  out_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  out_char_in = CHAR_ZERO + CHAR_BITS'(top_digit);
                  out_last_in = (dig_left_ff == DIG_W'(1));
                  bcd_in      = {bcd_ff[BCD_W-5:0], 4'd0};
                  dig_left_in = dig_left_ff - 1'b1;
                  if (dig_left_ff == DIG_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sign_ff      <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      dig_left_ff <= dig_left_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8 - CHAR_BITS){1'b0}}, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   `ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_CONV && bcd_ff == '0, "no start")
   `ASSERT_IMPLIES(a_emit_has_digit, state_ff == ST_EMIT, dig_left_ff != '0, "no digit left")
   `ASSERT_IMPLIES(a_bcd_digit, state_ff == ST_SKIP, top_digit <= 4'd9, "BCD digit out of range")
   `ASSERT_IMPLIES(a_sign_not_last, rsp_tvalid && out_char_ff == CHAR_MINUS, !rsp_tlast, "sign last")

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps
module tb_top;
   import itoa_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEFAULT;
   localparam int DATA_BITS    = ((VALUE_BITS + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic                 last;
   } ascii_char_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;   // value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // char_code
   logic                 rsp_tlast;         // last_char

   ascii_char_type pending_chars[$];
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_left     = 0;
   int          error_count   = 0;

   signed_int_to_decimal_ascii_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Appends the characters of one value's decimal text, sign first.
   function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0]            digits[0:19];
      int                    nd;
      ascii_char_type        ch;
      mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      nd  = 0;
      do begin
         digits[nd] = 4'(mag % 10);
         mag        = mag / 10;
         nd++;
      end while (mag != 0 && nd < 20);
      if (value[VALUE_BITS-1]) begin
         ch.code = CHAR_MINUS;
         ch.last = 1'b0;
         pending_chars.push_back(ch);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         ch.code = CHAR_ZERO + CHAR_BITS'(digits[i]);
         ch.last = (i == 0);
         pending_chars.push_back(ch);
      end
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
   endtask

   // Predicts on every accepted value and checks every accepted character.
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_decimal_text(req_tdata[VALUE_BITS-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               note_failure($sformatf("unexpected character %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata[CHAR_BITS-1:0] !== want.code)
                  note_failure($sformatf("char_code exp %h got %h", want.code,
                                         rsp_tdata[CHAR_BITS-1:0]));
               if (rsp_tdata[7:CHAR_BITS] !== '0)
                  note_failure($sformatf("tdata padding exp 0 got %h", rsp_tdata[7:CHAR_BITS]));
               if (rsp_tlast !== want.last)
                  note_failure($sformatf("last_char exp %b got %b", want.last, rsp_tlast));
            end
         end
      end
   end

   // Receiver: random stalls, plus long holds counted down here.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one value, idling at random first; returns once the transfer happens.
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_BITS'(value);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_text();
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      int p;
      int k;
      logic [VALUE_BITS-1:0] v;
      k = $urandom_range(9);
      p = 1;
      repeat (k) p = p * 10;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $urandom_range(p, 0);
         2: v = p + $urandom_range(2) - 1;   // around a power of ten
         default: begin
            case ($urandom_range(3))
               0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
               1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
      endcase
      if ($urandom_range(1)) v = ~v + 1'b1;
      return v;
   endfunction

   task automatic test_directed_values();
      int vals[$];
      vals = '{0, 1, -1, 7, -9, 9, 10, -10, 99, 100, -100, 2147483647, 32'sh8000_0000,
               -2147483647, 1000000000, -1000000000, 999999999, 123456789, -987654321,
               32'h5555_5555, 32'hAAAA_AAAA, 65536, -65536};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (vals[i]) send_value(vals[i]);
      idle_sender();
      wait_for_text();
   endtask

   task automatic test_random_phase(input int count, input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_value(random_value());
      idle_sender();
      wait_for_text();
   endtask

   // Long receiver hold while values keep coming: the input must stall.
   task automatic test_output_hold();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_left = 400;
      repeat (30) send_value(random_value());
      idle_sender();
      wait_for_text();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_random_phase(100, 0, 0);
      test_random_phase(100, 59, 0);
      test_random_phase(100, 0, 59);
      test_random_phase(100, 18, 18);
      test_output_hold();
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0)
         note_failure($sformatf("%0d characters never arrived", pending_chars.size()));
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl
rtl/itoa_pkg.sv
rtl/signed_int_to_decimal_ascii_unit.sv
dv/tb_top.sv
